>>> rtl/core/vlpd_pkg.sv
// Shared types and constants for the varint length-prefixed deframer.
// No dependencies; used by every module under rtl/core.
`default_nettype none

package vlpd_pkg;

  // widths of the datapath
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned LEN_W    = 32;
  localparam int unsigned SLEN_W   = 16;
  localparam int unsigned KIND_W   = 3;
  localparam int unsigned ERR_W    = 2;
  localparam int unsigned GRP_CNT_W = 3;

  // peer address bytes at the head of the session
  localparam int unsigned ADDR_BYTES = 4;

  // leb128 length groups
  localparam int unsigned GROUP_BITS = 7;
  localparam int unsigned MAX_GROUPS = 5;
  localparam int unsigned LAST_SHIFT = (MAX_GROUPS - 1) * GROUP_BITS;
  localparam int unsigned SHAMT_W    = 5;

  // limit register reset values
  localparam logic [LEN_W-1:0]  MAX_CONTENT_RST = 32'd4194304;
  localparam logic [SLEN_W-1:0] MAX_KEY_RST     = 16'd4096;
  localparam logic [SLEN_W-1:0] MAX_SIG_RST     = 16'd512;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_MAX_CONTENT = 2'd0,
    REG_MAX_KEY     = 2'd1,
    REG_MAX_SIG     = 2'd2
  } reg_idx_e;

  // frame position of a byte, as reported in the kind field
  typedef enum logic [KIND_W-1:0] {
    KIND_ADDR    = 3'd0,
    KIND_KEYLEN  = 3'd1,
    KIND_KEY     = 3'd2,
    KIND_SIGLEN  = 3'd3,
    KIND_SIG     = 3'd4,
    KIND_CONTLEN = 3'd5,
    KIND_CONT    = 3'd6
  } kind_e;

  // sticky error codes
  localparam logic [ERR_W-1:0] ERR_NONE    = 2'd0;
  localparam logic [ERR_W-1:0] ERR_CONTENT = 2'd1;
  localparam logic [ERR_W-1:0] ERR_KEY     = 2'd2;
  localparam logic [ERR_W-1:0] ERR_SIG     = 2'd3;

  // limits handed from the register file to the parser
  typedef struct packed {
    logic [LEN_W-1:0]  max_content;
    logic [SLEN_W-1:0] max_key;
    logic [SLEN_W-1:0] max_sig;
  } limits_t;

  // one tagged output word
  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic [KIND_W-1:0] kind;
    logic              field_end;
    logic [LEN_W-1:0]  field_length;
    logic [ERR_W-1:0]  error;
  } result_t;

endpackage

`default_nettype wire

>>> rtl/core/vlpd_cfg_regs.sv
// Length limit registers of the deframer, written through a plain write port.
// Depends on vlpd_pkg.
`default_nettype none

module vlpd_cfg_regs (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [1:0]                  cfg_idx_i,
  input  wire logic [vlpd_pkg::LEN_W-1:0]  cfg_data_i,
  output vlpd_pkg::limits_t                limits_o
);

  vlpd_pkg::limits_t limits_q;

  // register writes, index beyond the list is dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limits_q.max_content <= vlpd_pkg::MAX_CONTENT_RST;
      limits_q.max_key     <= vlpd_pkg::MAX_KEY_RST;
      limits_q.max_sig     <= vlpd_pkg::MAX_SIG_RST;
    end else if (cfg_we_i) begin
      case (vlpd_pkg::reg_idx_e'(cfg_idx_i))
        vlpd_pkg::REG_MAX_CONTENT: begin
          limits_q.max_content <= cfg_data_i;
        end
        vlpd_pkg::REG_MAX_KEY: begin
          limits_q.max_key <= cfg_data_i[vlpd_pkg::SLEN_W-1:0];
        end
        vlpd_pkg::REG_MAX_SIG: begin
          limits_q.max_sig <= cfg_data_i[vlpd_pkg::SLEN_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign limits_o = limits_q;

endmodule

`default_nettype wire

>>> rtl/core/vlpd_parse.sv
// Frame sequence tracker: phase, byte counter, leb128 accumulator and sticky
// error, with the single-pass next-state logic. Depends on vlpd_pkg.
`default_nettype none

module vlpd_parse #(
  parameter int unsigned ADDR_BYTES = vlpd_pkg::ADDR_BYTES
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         step_i,
  input  wire logic [vlpd_pkg::BYTE_W-1:0]  byte_i,
  input  wire vlpd_pkg::limits_t            limits_i,
  output vlpd_pkg::result_t                 result_o
);

  // one-hot phase of the frame sequence
  typedef enum logic [6:0] {
    PH_ADDR    = 7'b0000001,
    PH_KEYLEN  = 7'b0000010,
    PH_KEY     = 7'b0000100,
    PH_SIGLEN  = 7'b0001000,
    PH_SIG     = 7'b0010000,
    PH_CONTLEN = 7'b0100000,
    PH_CONT    = 7'b1000000
  } phase_e;

  localparam int unsigned LW = vlpd_pkg::LEN_W;

  phase_e                              phase_q, phase_d;
  logic [LW-1:0]                       cnt_q, cnt_d;
  logic [LW-1:0]                       acc_q, acc_d;
  logic [vlpd_pkg::GRP_CNT_W-1:0]      grp_q, grp_d;
  logic [vlpd_pkg::ERR_W-1:0]          err_q, err_d;

  logic [LW-1:0]                       limit;
  logic [vlpd_pkg::ERR_W-1:0]          code;
  phase_e                              data_ph;
  phase_e                              skip_ph;
  phase_e                              after_ph;
  vlpd_pkg::kind_e                     kind;
  logic [vlpd_pkg::SHAMT_W-1:0]        shamt;
  logic [LW-1:0]                       grp_ext;
  logic [LW-1:0]                       acc_new;
  logic [LW-1:0]                       cnt_inc;
  logic                                sixth;
  logic                                wide;
  logic                                last;
  logic                                end_c;
  logic                                over_c;
  logic [LW-1:0]                       flen_c;

  // per-phase limit, error code and follow-on phases
  always_comb begin
    limit    = limits_i.max_content;
    code     = vlpd_pkg::ERR_CONTENT;
    data_ph  = PH_CONT;
    skip_ph  = PH_SIGLEN;
    after_ph = PH_SIGLEN;
    kind     = vlpd_pkg::KIND_ADDR;
    unique case (phase_q)
      PH_ADDR: begin
        kind     = vlpd_pkg::KIND_ADDR;
        after_ph = PH_KEYLEN;
      end
      PH_KEYLEN: begin
        kind    = vlpd_pkg::KIND_KEYLEN;
        limit   = {{(LW-vlpd_pkg::SLEN_W){1'b0}}, limits_i.max_key};
        code    = vlpd_pkg::ERR_KEY;
        data_ph = PH_KEY;
        skip_ph = PH_SIGLEN;
      end
      PH_KEY: begin
        kind     = vlpd_pkg::KIND_KEY;
        after_ph = PH_SIGLEN;
      end
      PH_SIGLEN: begin
        kind    = vlpd_pkg::KIND_SIGLEN;
        limit   = {{(LW-vlpd_pkg::SLEN_W){1'b0}}, limits_i.max_sig};
        code    = vlpd_pkg::ERR_SIG;
        data_ph = PH_SIG;
        skip_ph = PH_CONTLEN;
      end
      PH_SIG: begin
        kind     = vlpd_pkg::KIND_SIG;
        after_ph = PH_CONTLEN;
      end
      PH_CONTLEN: begin
        kind = vlpd_pkg::KIND_CONTLEN;
      end
      PH_CONT: begin
        kind     = vlpd_pkg::KIND_CONT;
        after_ph = PH_SIGLEN;
      end
      default: begin
      end
    endcase
  end

  // leb128 group placement and overflow checks
  assign shamt   = vlpd_pkg::SHAMT_W'({2'b00, grp_q} * 5'(vlpd_pkg::GROUP_BITS));
  assign grp_ext = {{(LW-vlpd_pkg::GROUP_BITS){1'b0}}, byte_i[vlpd_pkg::GROUP_BITS-1:0]};
  assign acc_new = acc_q | (grp_ext << shamt);
  assign sixth   = (grp_q >= vlpd_pkg::GRP_CNT_W'(vlpd_pkg::MAX_GROUPS));
  assign wide    = (grp_q == vlpd_pkg::GRP_CNT_W'(vlpd_pkg::MAX_GROUPS - 1)) &&
                   (byte_i[vlpd_pkg::GROUP_BITS-1:LW-vlpd_pkg::LAST_SHIFT] != '0);
  assign last    = ~byte_i[vlpd_pkg::BYTE_W-1];
  assign cnt_inc = cnt_q + 32'd1;

  // next state for one word
  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    acc_d   = acc_q;
    grp_d   = grp_q;
    err_d   = err_q;
    end_c   = 1'b0;
    over_c  = 1'b0;
    flen_c  = '0;
    if (err_q == vlpd_pkg::ERR_NONE) begin
      unique case (phase_q)
        PH_KEYLEN, PH_SIGLEN, PH_CONTLEN: begin
          if (sixth) begin
            end_c  = 1'b1;
            over_c = 1'b1;
            flen_c = acc_q;
          end else begin
            acc_d  = acc_new;
            grp_d  = grp_q + 3'd1;
            end_c  = last || wide;
            over_c = wide || (last && (acc_new > limit));
            flen_c = end_c ? acc_new : '0;
          end
          if (end_c) begin
            if (over_c) begin
              err_d = code;
            end else if (flen_c == '0) begin
              phase_d = skip_ph;
              cnt_d   = '0;
              acc_d   = '0;
              grp_d   = '0;
            end else begin
              phase_d = data_ph;
              cnt_d   = '0;
              grp_d   = '0;
            end
          end
        end
        PH_ADDR: begin
          cnt_d = cnt_inc;
          if (cnt_inc >= LW'(ADDR_BYTES)) begin
            end_c   = 1'b1;
            phase_d = after_ph;
            cnt_d   = '0;
            acc_d   = '0;
            grp_d   = '0;
          end
        end
        PH_KEY, PH_SIG, PH_CONT: begin
          cnt_d = cnt_inc;
          if (cnt_inc >= acc_q) begin
            end_c   = 1'b1;
            phase_d = after_ph;
            cnt_d   = '0;
            acc_d   = '0;
            grp_d   = '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // state registers, advanced once per word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_ADDR;
      cnt_q   <= '0;
      acc_q   <= '0;
      grp_q   <= '0;
      err_q   <= vlpd_pkg::ERR_NONE;
    end else if (step_i) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      acc_q   <= acc_d;
      grp_q   <= grp_d;
      err_q   <= err_d;
    end
  end

  // tagged word for the result register
  assign result_o.data_byte    = byte_i;
  assign result_o.kind         = kind;
  assign result_o.field_end    = end_c;
  assign result_o.field_length = flen_c;
  assign result_o.error        = err_d;

`ifndef SYNTH
  // once an error is raised, phase and code stay put
  a_err_freezes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (err_q != vlpd_pkg::ERR_NONE) |=> ($stable(err_q) && $stable(phase_q)))
    else $error("error or phase changed after a sticky error");

  // a length is only reported on a word that closes its field
  a_len_on_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (flen_c != '0) |-> end_c)
    else $error("field length reported without field end");

  // the group counter never runs past the sixth-byte check
  a_grp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (grp_q <= vlpd_pkg::GRP_CNT_W'(vlpd_pkg::MAX_GROUPS)))
    else $error("length group counter out of range");
`endif

endmodule

`default_nettype wire

>>> rtl/core/varint_length_prefixed_deframer_unit.sv
// Top level of the varint length-prefixed deframer: input register, parser
// and result register. Depends on vlpd_pkg, vlpd_cfg_regs and vlpd_parse.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o / rx_byte_i) takes one received
//   byte per word. Output channel (out_valid_o / out_ready_i) gives one
//   tagged word per byte: the byte, its kind, a field end flag, the decoded
//   length on the byte that closes a length field, and the sticky error.
//   A byte taken into the input register moves on into the result register
//   when the output side is free, and out_valid_o rises once it is there.
//   Throughput: one word per cycle while out_ready_i stays high, set by
//   the single-pass parser between the input register and the result register.
//   When the receiver stalls, the result register holds its word and the
//   input register still takes one more byte; in_ready_o drops only when
//   both are full and out_ready_i is low.
//   Reset: limits return to their defaults, the parser waits for the peer
//   address, the error clears and both registers empty.
//   The limit registers are written through cfg_we_i / cfg_idx_i / cfg_data_i,
//   by the user only while the block holds no word; the block does not enforce it.
`default_nettype none

module varint_length_prefixed_deframer_unit #(
  parameter int unsigned ADDR_BYTES = vlpd_pkg::ADDR_BYTES
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // configuration write port
  input  wire logic                         cfg_we_i,
  input  wire logic [1:0]                   cfg_idx_i,
  input  wire logic [vlpd_pkg::LEN_W-1:0]   cfg_data_i,
  // byte input
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [vlpd_pkg::BYTE_W-1:0]  rx_byte_i,
  // tagged output
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [vlpd_pkg::BYTE_W-1:0]       data_byte_o,
  output logic [vlpd_pkg::KIND_W-1:0]       kind_o,
  output logic                              field_end_o,
  output logic [vlpd_pkg::LEN_W-1:0]        field_length_o,
  output logic [vlpd_pkg::ERR_W-1:0]        error_o
);

  vlpd_pkg::limits_t                limits;
  vlpd_pkg::result_t                result;
  vlpd_pkg::result_t                out_q;
  logic [vlpd_pkg::BYTE_W-1:0]      in_byte_q;
  logic                             in_valid_q, in_valid_d;
  logic                             out_valid_q, out_valid_d;
  logic                             in_fire;
  logic                             advance;

  // limit registers
  vlpd_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .limits_o   (limits)
  );

  // handshake between the two registers
  assign advance     = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || advance;
  assign in_fire     = in_valid_i && in_ready_o;
  assign in_valid_d  = in_fire || (in_valid_q && !advance);
  assign out_valid_d = advance || (out_valid_q && !out_ready_i);

  // parser
  vlpd_parse #(
    .ADDR_BYTES (ADDR_BYTES)
  ) u_parse (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .byte_i   (in_byte_q),
    .limits_i (limits),
    .result_o (result)
  );

  // valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_byte_q <= rx_byte_i;
    end
    if (advance) begin
      out_q <= result;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign data_byte_o    = out_q.data_byte;
  assign kind_o         = out_q.kind;
  assign field_end_o    = out_q.field_end;
  assign field_length_o = out_q.field_length;
  assign error_o        = out_q.error;

`ifndef SYNTH
  // input side only backs up when both registers are full and stalled
  a_ready_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (in_valid_q && out_valid_q && !out_ready_i))
    else $error("input stalled while a register was free");

  // a word moved into the result register is shown at the next edge
  a_adv_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_o)
    else $error("result register lost a word");

  // a stalled output word stays valid and unchanged
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_q)))
    else $error("output word changed while stalled");
`endif

endmodule

`default_nettype wire

>>> verif/varint_length_prefixed_deframer_unit_test.sv
// Self-checking bench for varint_length_prefixed_deframer_unit: frame streams
// with leb128 lengths, a tagging predictor and a scoreboard on every word.
// Depends on vlpd_pkg and the deframer rtl.

module varint_length_prefixed_deframer_unit_test;

  // register index past the end of the map, writes must be dropped
  localparam logic [1:0] REG_UNUSED = 2'd3;

  // ways of ending the run with a sticky error
  localparam int unsigned TAIL_SIG_OVER   = 0;
  localparam int unsigned TAIL_CONT_OVER  = 1;
  localparam int unsigned TAIL_SIXTH_BYTE = 2;
  localparam int unsigned TAIL_WIDE_FIFTH = 3;

  localparam int unsigned PHASE_BYTES = 55;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned DRAIN_WAIT  = 8;

  logic                                clk_i          = 1'b0;
  logic                                rst_ni         = 1'b0;
  logic                                cfg_we_i       = 1'b0;
  logic [1:0]                          cfg_idx_i      = '0;
  logic [vlpd_pkg::LEN_W-1:0]          cfg_data_i     = '0;
  logic                                in_valid_i     = 1'b0;
  logic                                in_ready_o;
  logic [vlpd_pkg::BYTE_W-1:0]         rx_byte_i      = '0;
  logic                                out_valid_o;
  logic                                out_ready_i    = 1'b0;
  logic [vlpd_pkg::BYTE_W-1:0]         data_byte_o;
  logic [vlpd_pkg::KIND_W-1:0]         kind_o;
  logic                                field_end_o;
  logic [vlpd_pkg::LEN_W-1:0]          field_length_o;
  logic [vlpd_pkg::ERR_W-1:0]          error_o;

  // bytes waiting to be offered and tagged words waiting to come out
  logic [vlpd_pkg::BYTE_W-1:0]         rx_pending[$];
  vlpd_pkg::result_t                   tagged_expect[$];

  // predictor copy of the limit registers
  logic [vlpd_pkg::LEN_W-1:0]          lim_content = vlpd_pkg::MAX_CONTENT_RST;
  logic [vlpd_pkg::SLEN_W-1:0]         lim_key     = vlpd_pkg::MAX_KEY_RST;
  logic [vlpd_pkg::SLEN_W-1:0]         lim_sig     = vlpd_pkg::MAX_SIG_RST;

  // predictor copy of the parser state
  vlpd_pkg::kind_e                     cur_kind     = vlpd_pkg::KIND_ADDR;
  logic [vlpd_pkg::LEN_W-1:0]          kind_bytes   = '0;
  logic [vlpd_pkg::LEN_W-1:0]          len_acc      = '0;
  logic [2:0]                          groups_taken = '0;
  logic [vlpd_pkg::ERR_W-1:0]          sticky_err   = vlpd_pkg::ERR_NONE;

  int unsigned send_idle_pct = 34;
  int unsigned recv_idle_pct = 47;
  int unsigned bytes_taken   = 0;
  int unsigned words_checked = 0;
  int unsigned fail_count    = 0;
  int unsigned idle_cycles   = 0;

  varint_length_prefixed_deframer_unit i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .data_byte_o    (data_byte_o),
    .kind_o         (kind_o),
    .field_end_o    (field_end_o),
    .field_length_o (field_length_o),
    .error_o        (error_o)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------- predictor

  task automatic enter_field(input vlpd_pkg::kind_e next);
    cur_kind     = next;
    kind_bytes   = '0;
    len_acc      = '0;
    groups_taken = '0;
  endtask

  // tag one accepted byte and queue the word it should produce
  task automatic tag_byte(input logic [vlpd_pkg::BYTE_W-1:0] b);
    vlpd_pkg::result_t r;
    logic [31:0]       limit;
    logic [1:0]        code;
    vlpd_pkg::kind_e   data_kind;
    vlpd_pkg::kind_e   skip_kind;
    logic [63:0]       sum;
    logic              over;
    r           = '0;
    r.data_byte = b;
    r.kind      = cur_kind;
    over        = 1'b0;
    limit       = '0;
    code        = vlpd_pkg::ERR_NONE;
    data_kind   = vlpd_pkg::KIND_KEY;
    skip_kind   = vlpd_pkg::KIND_SIGLEN;
    if (sticky_err == vlpd_pkg::ERR_NONE) begin
      case (cur_kind)
        vlpd_pkg::KIND_KEYLEN, vlpd_pkg::KIND_SIGLEN, vlpd_pkg::KIND_CONTLEN: begin
          if (cur_kind == vlpd_pkg::KIND_KEYLEN) begin
            limit = {16'd0, lim_key};
            code = vlpd_pkg::ERR_KEY;
            data_kind = vlpd_pkg::KIND_KEY;
            skip_kind = vlpd_pkg::KIND_SIGLEN;
          end else if (cur_kind == vlpd_pkg::KIND_SIGLEN) begin
            limit = {16'd0, lim_sig};
            code = vlpd_pkg::ERR_SIG;
            data_kind = vlpd_pkg::KIND_SIG;
            skip_kind = vlpd_pkg::KIND_CONTLEN;
          end else begin
            limit = lim_content;
            code = vlpd_pkg::ERR_CONTENT;
            data_kind = vlpd_pkg::KIND_CONT;
            skip_kind = vlpd_pkg::KIND_SIGLEN;
          end
          if (groups_taken >= vlpd_pkg::MAX_GROUPS) begin
            // one group too many, oversize whatever the byte holds
            over = 1'b1;
            r.field_end = 1'b1;
          end else begin
            sum = {32'd0, len_acc} | ({57'd0, b[6:0]} << (7 * groups_taken));
            if (sum[63:32] != 0) over = 1'b1;
            len_acc = sum[31:0];
            groups_taken = groups_taken + 3'd1;
            if (!b[7]) begin
              r.field_end = 1'b1;
              if (len_acc > limit) over = 1'b1;
            end else if (over) begin
              r.field_end = 1'b1;
            end
          end
          if (r.field_end) begin
            r.field_length = len_acc;
            if (over) begin
              sticky_err = code;
            end else if (len_acc == 0) begin
              enter_field(skip_kind);
            end else begin
              cur_kind = data_kind;
              kind_bytes = '0;
              groups_taken = '0;
            end
          end
        end
        vlpd_pkg::KIND_ADDR: begin
          kind_bytes = kind_bytes + 1;
          if (kind_bytes >= vlpd_pkg::ADDR_BYTES) begin
            r.field_end = 1'b1;
            enter_field(vlpd_pkg::KIND_KEYLEN);
          end
        end
        default: begin
          // payload bytes of key, signature or content
          kind_bytes = kind_bytes + 1;
          if (kind_bytes >= len_acc) begin
            r.field_end = 1'b1;
            if (cur_kind == vlpd_pkg::KIND_KEY) enter_field(vlpd_pkg::KIND_SIGLEN);
            else if (cur_kind == vlpd_pkg::KIND_SIG) enter_field(vlpd_pkg::KIND_CONTLEN);
            else enter_field(vlpd_pkg::KIND_SIGLEN);
          end
        end
      endcase
    end
    r.error = sticky_err;
    tagged_expect.push_back(r);
  endtask

  // ------------------------------------------------------------ stream build

  function automatic int unsigned leb_groups(input logic [31:0] value);
    int unsigned n;
    n = 1;
    while (n < vlpd_pkg::MAX_GROUPS && (value >> (7 * n)) != 0) n++;
    return n;
  endfunction

  // leb128 encoding spread over a given number of groups
  task automatic push_length(input logic [31:0] value, input int unsigned groups);
    for (int unsigned g = 0; g < groups; g++) begin
      rx_pending.push_back({g != groups - 1, 7'(value >> (7 * g))});
    end
  endtask

  // canonical now and then padded with empty groups
  task automatic push_len_field(input logic [31:0] value);
    int unsigned n;
    n = leb_groups(value);
    if ($urandom_range(0, 3) == 0) n = $urandom_range(n, vlpd_pkg::MAX_GROUPS);
    push_length(value, n);
  endtask

  task automatic push_payload(input int unsigned n);
    repeat (n) rx_pending.push_back(8'($urandom));
  endtask

  task automatic push_record(input logic [31:0] sig_len, input logic [31:0] cont_len);
    push_len_field(sig_len);
    push_payload(sig_len);
    push_len_field(cont_len);
    push_payload(cont_len);
  endtask

  // mostly short fields, sometimes exactly at a small limit
  function automatic logic [31:0] pick_length(input logic [31:0] limit);
    logic [31:0] cap;
    cap = (limit < 6) ? limit : 32'd6;
    if (limit <= 24 && $urandom_range(0, 3) == 0) return limit;
    return $urandom_range(0, cap);
  endfunction

  task automatic push_records(input int unsigned budget);
    int unsigned start;
    start = rx_pending.size() + bytes_taken;
    while (rx_pending.size() + bytes_taken - start < budget) begin
      push_record(pick_length({16'd0, lim_sig}), pick_length(lim_content));
    end
  endtask

  task automatic write_limit(input logic [1:0] idx, input logic [31:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      vlpd_pkg::REG_MAX_CONTENT: lim_content = data;
      vlpd_pkg::REG_MAX_KEY:     lim_key = data[15:0];
      vlpd_pkg::REG_MAX_SIG:     lim_sig = data[15:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (rx_pending.size() != 0 || in_valid_i || tagged_expect.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  // ------------------------------------------------------------------ driver

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        tag_byte(rx_byte_i);
        bytes_taken++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (rx_pending.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid_i <= 1'b1;
          rx_byte_i  <= rx_pending.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ----------------------------------------------------------------- monitor

  task automatic compare_field(input string fname, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
      fail_count++;
    end
  endtask

  task automatic check_word();
    vlpd_pkg::result_t want;
    if (tagged_expect.size() == 0) begin
      $display("%0t: word with nothing expected, expected none, actual byte %02h kind %0d",
               $time, data_byte_o, kind_o);
      fail_count++;
    end else begin
      want = tagged_expect.pop_front();
      compare_field("data_byte", 32'(want.data_byte), 32'(data_byte_o));
      compare_field("kind", 32'(want.kind), 32'(kind_o));
      compare_field("field_end", 32'(want.field_end), 32'(field_end_o));
      compare_field("field_length", want.field_length, field_length_o);
      compare_field("error", 32'(want.error), 32'(error_o));
    end
    words_checked++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) check_word();
      out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // cycles without any word moving on either side
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("varint_length_prefixed_deframer_unit_test: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ----------------------------------------------------------------- stimulus

  initial begin
    int unsigned tail_plan;
    logic [31:0] v;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed opening at reset limits: address extremes, key, zero fields
    rx_pending.push_back(8'h00);
    rx_pending.push_back(8'hFF);
    rx_pending.push_back(8'h55);
    rx_pending.push_back(8'hAA);
    if ($urandom_range(0, 1) == 0) begin
      push_length(0, 1);
    end else begin
      push_length(2, 2);
      rx_pending.push_back(8'hFF);
      rx_pending.push_back(8'h00);
    end
    push_length(0, 1);
    push_length(1, vlpd_pkg::MAX_GROUPS);
    rx_pending.push_back(8'hFF);
    push_length(1, 1);
    rx_pending.push_back(8'h00);
    push_length(0, 2);
    push_length(3, 1);
    push_payload(3);
    push_length(2, 1);
    push_payload(2);
    push_records(PHASE_BYTES);
    wait_drained();

    // maxima, masked key write, a write past the map, one content needing two groups
    send_idle_pct = 47;
    recv_idle_pct = 34;
    write_limit(vlpd_pkg::REG_MAX_CONTENT, 32'hFFFF_FFFF);
    write_limit(REG_UNUSED, 32'h0);
    write_limit(vlpd_pkg::REG_MAX_KEY, 32'hABCD_FFFF);
    write_limit(vlpd_pkg::REG_MAX_SIG, 32'hFFFF_FFFF);
    push_record(pick_length({16'd0, lim_sig}), $urandom_range(128, 160));
    push_records(PHASE_BYTES);
    wait_drained();

    // no signatures allowed, small content limit
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_limit(vlpd_pkg::REG_MAX_SIG, 32'h0);
    write_limit(vlpd_pkg::REG_MAX_KEY, 32'h0);
    write_limit(vlpd_pkg::REG_MAX_CONTENT, $urandom_range(1, 8));
    push_records(PHASE_BYTES);
    wait_drained();

    // no content allowed, small signature limit
    write_limit(vlpd_pkg::REG_MAX_CONTENT, 32'h0);
    write_limit(vlpd_pkg::REG_MAX_SIG, $urandom_range(1, 6));
    push_records(PHASE_BYTES);

    // finish on one oversize length, then bytes behind the frozen parser
    tail_plan = $urandom_range(TAIL_SIG_OVER, TAIL_WIDE_FIFTH);
    case (tail_plan)
      TAIL_SIG_OVER: begin
        v = $urandom;
        if (v <= lim_sig) v = {16'd0, lim_sig} + 1;
        push_length(v, leb_groups(v));
      end
      TAIL_CONT_OVER: begin
        push_length(0, 1);
        v = $urandom | 32'd1;
        push_length(v, leb_groups(v));
      end
      default: begin
        if ($urandom_range(0, 1) == 0) push_length(0, 1);
        repeat (vlpd_pkg::MAX_GROUPS - 1) begin
          rx_pending.push_back(8'h80 | 8'($urandom_range(0, 127)));
        end
        if (tail_plan == TAIL_SIXTH_BYTE) begin
          rx_pending.push_back(8'h80 | 8'($urandom_range(0, 15)));
          rx_pending.push_back(8'($urandom));
        end else begin
          rx_pending.push_back({1'($urandom), 7'($urandom_range(16, 127))});
        end
      end
    endcase
    push_payload(12);
    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("%0d bytes through four limit settings, %0d words checked, final error code %0d",
             bytes_taken, words_checked, sticky_err);
    $display("%0d words still expected, %0d failures", tagged_expect.size(), fail_count);
    if (fail_count == 0 && tagged_expect.size() == 0) begin
      $display("varint_length_prefixed_deframer_unit_test: clean");
    end else begin
      $display("varint_length_prefixed_deframer_unit_test: errors");
    end
    $finish;
  end

endmodule
